// ===== src/sm3_pkg.sv =====
`default_nettype none
package sm3_pkg;

  localparam logic [31:0] T_LOW    = 32'h79CC4519;
  localparam logic [31:0] T_HIGH   = 32'h7A879D8A;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  localparam logic [255:0] IV = {
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  // byte source for the word being loaded into the schedule window
  typedef enum logic [1:0] {
    SRC_MSG  = 2'd0,
    SRC_ZERO = 2'd1,
    SRC_LEN  = 2'd2,
    SRC_BLK  = 2'd3   // full block, every byte from the buffer
  } word_src_t;

  typedef struct packed {
    logic      absorb;     // write byte into block buffer
    logic      init_round; // load working regs from chain, clear round count
    logic      load_word;  // shift one word into schedule window
    word_src_t src;
    logic      pad_mark;   // place 0x80 at the fill position
    logic      round;      // run one compression round
    logic      fold;       // xor working regs into chain
    logic      reset_chain;
    logic      add_block;  // total_bits += 512
    logic      snap_len;   // latch message length
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] round_idx;
    logic [3:0] word_idx;
  } dp_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

// ===== src/sm3_if.sv =====
`default_nettype none
interface sm3_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] msg_byte;
  modport source (output valid, op, msg_byte, input ready);
  modport sink   (input valid, op, msg_byte, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        last_word;
  modport source (output valid, digest_word, last_word, input ready);
  modport sink   (input valid, digest_word, last_word, output ready);
endinterface
`default_nettype wire

// ===== src/sm3_datapath.sv =====
`default_nettype none
module sm3_datapath
  import sm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  input  wire logic [7:0]  msg_byte,
  input  wire logic [1:0]  out_sel,
  output dp_stat_t         stat,
  output logic [63:0]      digest
);

  logic [31:0]  buffer [16];  // block held as big-endian words
  logic [5:0]   fill;
  logic [63:0]  total_bits;
  logic [63:0]  length;
  logic [255:0] chain;
  logic [31:0]  a, b, c, d, e, f, g, h;
  logic [31:0]  w [16];   // w[j] .. w[j+15]
  logic [5:0]   round_idx;
  logic [3:0]   word_idx;
  logic [31:0]  tconst;

  // word currently loaded (full block, message, zero-padded, length)
  logic [31:0] load_w;
  always_comb begin
    logic [7:0] by [4];
    for (int k = 0; k < 4; k++) begin
      logic [5:0] pos;
      pos = {word_idx, 2'(k)};
      case (cmd.src)
        SRC_BLK:  by[k] = buffer[word_idx][8*(3-k) +: 8];
        SRC_MSG:  by[k] = (pos < fill) ? buffer[word_idx][8*(3-k) +: 8] :
                          ((pos == fill && cmd.pad_mark) ? PAD_MARK : 8'h00);
        SRC_ZERO: by[k] = (pos == fill && cmd.pad_mark) ? PAD_MARK : 8'h00;
        SRC_LEN:  by[k] = word_idx[0] ? length[8*(3-k) +: 8] : length[32+8*(3-k) +: 8];
        default:  by[k] = 8'h00;
      endcase
    end
    load_w = {by[0], by[1], by[2], by[3]};
  end

  logic [31:0] w_new, a12, ss1, ss2, ff, gg, tt1, tt2;
  always_comb begin
    w_new = p1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
    tconst = (round_idx < 6'd16) ? T_LOW : T_HIGH;
    a12 = rotl(a, 5'd12);
    ss1 = rotl(a12 + e + rotl(tconst, round_idx[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (round_idx < 6'd16) begin
      ff = a ^ b ^ c;
      gg = e ^ f ^ g;
    end else begin
      ff = (a & b) | (a & c) | (b & c);
      gg = (e & f) | (~e & g);
    end
    tt1 = ff + d + ss2 + (w[0] ^ w[4]);
    tt2 = gg + h + ss1 + w[0];
  end

  always_ff @(posedge clk) begin
    if (cmd.absorb) buffer[fill[5:2]][8*(~fill[1:0]) +: 8] <= msg_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      w[15] <= load_w;
      for (int k = 0; k < 15; k++) w[k] <= w[k+1];
    end else if (cmd.round) begin
      w[15] <= w_new;
      for (int k = 0; k < 15; k++) w[k] <= w[k+1];
    end
    if (cmd.snap_len) length <= total_bits + {55'd0, fill, 3'd0};
    if (cmd.init_round) begin
      {a, b, c, d, e, f, g, h} <= chain;
    end else if (cmd.round) begin
      d <= c; c <= rotl(b, 5'd9); b <= a; a <= tt1;
      h <= g; g <= rotl(f, 5'd19); f <= e; e <= p0(tt2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      total_bits <= '0;
      chain <= IV;
      round_idx <= '0;
      word_idx <= '0;
    end else begin
      if (cmd.absorb) fill <= fill + 6'd1;
      if (cmd.add_block) total_bits <= total_bits + 64'd512;
      if (cmd.init_round) begin
        round_idx <= '0;
        word_idx <= '0;
      end
      if (cmd.load_word) word_idx <= word_idx + 4'd1;
      if (cmd.round) round_idx <= round_idx + 6'd1;
      if (cmd.fold) chain <= chain ^ {a, b, c, d, e, f, g, h};
      if (cmd.reset_chain) begin
        chain <= IV;
        fill <= '0;
        total_bits <= '0;
      end
    end
  end

  assign stat = '{fill: fill, round_idx: round_idx, word_idx: word_idx};
  assign digest = chain[255 - 64*out_sel -: 64];

endmodule
`default_nettype wire

// ===== src/sm3_ctrl.sv =====
`default_nettype none
module sm3_ctrl
  import sm3_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_op,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_sel,
  input  wire dp_stat_t   stat,
  output dp_cmd_t         cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_RND  = 7'b0000100,
    S_FOLD = 7'b0001000,
    S_EMIT = 7'b0010000,
    S_PREP = 7'b0100000,
    S_LENC = 7'b1000000
  } state_t;

  // phase of the finishing pass
  typedef enum logic [1:0] {
    PH_DATA  = 2'd0,  // ordinary full block
    PH_PAD1  = 2'd1,  // block holding the pad mark (length too if it fits)
    PH_PAD2  = 2'd2   // extra block: zeros and length
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   two_blk, two_blk_next;
  logic [1:0] sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_DATA;
      two_blk <= 1'b0;
      out_sel <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      two_blk <= two_blk_next;
      out_sel <= sel_next;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.src = SRC_MSG;
    state_next = state;
    phase_next = phase;
    two_blk_next = two_blk;
    sel_next = out_sel;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_op) begin
            cmd.absorb = 1'b1;
            if (stat.fill == 6'd63) begin
              cmd.init_round = 1'b1;
              phase_next = PH_DATA;
              state_next = S_LOAD;
            end
          end else begin
            cmd.snap_len = 1'b1;
            state_next = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd.init_round = 1'b1;
        two_blk_next = (stat.fill > 6'd55);
        phase_next = PH_PAD1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_word = 1'b1;
        unique case (phase)
          PH_DATA: cmd.src = SRC_BLK;
          PH_PAD1: begin
            cmd.pad_mark = 1'b1;
            cmd.src = (!two_blk && stat.word_idx >= 4'd14) ? SRC_LEN : SRC_MSG;
          end
          PH_PAD2: cmd.src = (stat.word_idx >= 4'd14) ? SRC_LEN : SRC_ZERO;
          default: cmd.src = SRC_MSG;
        endcase
        if (stat.word_idx == 4'd15) state_next = S_RND;
      end
      S_RND: begin
        cmd.round = 1'b1;
        if (stat.round_idx == 6'd63) state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        unique case (phase)
          PH_DATA: begin
            cmd.add_block = 1'b1;
            state_next = S_IDLE;
          end
          PH_PAD1: begin
            if (two_blk) begin
              phase_next = PH_PAD2;
              state_next = S_LENC;
            end else begin
              sel_next = '0;
              state_next = S_EMIT;
            end
          end
          default: begin
            sel_next = '0;
            state_next = S_EMIT;
          end
        endcase
      end
      S_LENC: begin
        cmd.init_round = 1'b1;
        state_next = S_LOAD;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          sel_next = out_sel + 2'd1;
          if (out_sel == 2'd3) begin
            cmd.reset_chain = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/sm3_hash_engine.sv =====
`default_nettype none
// SM3 hash engine. Absorb transactions take one byte per cycle; the 64th byte of a
// block stalls input while the block is compressed (16 word loads, 64 rounds of
// the single round unit, one fold). A finish transaction compresses one padded
// block, or two when the pad mark falls beyond byte 55, then the digest leaves as
// four 64-bit words, most significant first, the last flagged by last_word. The
// engine then returns to the initial value for the next message.
module sm3_hash_engine
  import sm3_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  sm3_in_if.sink   in_ch,
  sm3_out_if.source out_ch
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [1:0] sel;
  logic [63:0] digest;

  sm3_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_sel  (sel),
    .stat, .cmd
  );

  sm3_datapath u_dp (
    .clk, .rst, .cmd,
    .msg_byte(in_ch.msg_byte),
    .out_sel (sel),
    .stat, .digest
  );

  assign out_ch.digest_word = digest;
  assign out_ch.last_word   = (sel == 2'd3);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("input taken while emitting");
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last_word) |=> !out_ch.valid)
    else $error("emit did not end after last word");
  a_round_cmd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.round && cmd.load_word)) else $error("round and load together");

endmodule
`default_nettype wire
